// ===== hw/rtl/gbi_pkg.sv =====
// Shared types and constants for the grid bilinear interpolator.
// No dependencies; used by the core and the testbench.
`default_nettype none
package gbi_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int FRAC_W      = 16;
  localparam int CNT_W       = 7;
  localparam int STORE_AW    = 12;
  localparam int STORE_DEPTH = 4096;

  // Stream payload layout
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 32;
  localparam int IDX_LSB     = 0;
  localparam int VAL_LSB     = 12;
  localparam int XC_LSB      = 44;
  localparam int YC_LSB      = 76;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic signed [SAMPLE_W-1:0] ONE_Q16 = 32'sh0001_0000;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_X_LOWER = 3'd0,
    CFG_X_UPPER = 3'd1,
    CFG_Y_LOWER = 3'd2,
    CFG_Y_UPPER = 3'd3,
    CFG_X_COUNT = 3'd4,
    CFG_Y_COUNT = 3'd5
  } cfg_reg_t;

  // Where a coordinate falls on its axis
  typedef enum logic [1:0] {
    AXIS_LOW  = 2'd0,
    AXIS_MID  = 2'd1,
    AXIS_HIGH = 2'd2
  } axis_kind_t;

  typedef struct packed {
    logic                  is_query;
    logic [STORE_AW-1:0]   idx;
    logic [SAMPLE_W-1:0]   value;
  } item_meta_t;

endpackage
`default_nettype wire

// ===== hw/rtl/gbi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; instanced by the interpolator core.
`default_nettype none
module gbi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/grid_bilinear_interpolator_core.sv =====
// Bilinear interpolator over a uniform grid of Q16.16 samples, fully pipelined.
// Depends on gbi_pkg and gbi_ram (four replicas of the sample store).
//
//  channel | ports                        | payload
//  --------+------------------------------+----------------------------------------------
//  in      | in_tvalid/in_tready          | tuser: req_type; tdata: index, value, x, y
//  out     | out_tvalid/out_tready        | tdata: interp_value
//  cfg     | cfg_we/cfg_addr/cfg_wdata    | register index and write data, no read-back
//
// One request per cycle while the output is not stalled. A query passes S1 to S3,
// the restoring divider (one quotient bit per stage), S4 to S11 and the output
// register. Loads write the store at the read stage, so order is kept.
// Reset (synchronous, rst_n low) clears valid bits and sets config to defaults;
// the store is not cleared. Backpressure stalls the whole pipeline only when its
// last stage holds a result and the output register is still full.
`default_nettype none
module grid_bilinear_interpolator_core #(
  parameter int MAX_X_POINTS = 64,
  parameter int MAX_Y_POINTS = 64,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata, low bit up: entry_index[11:0], entry_value[43:12],
  //   x_coord[75:44], y_coord[107:76], zero pad[111:108]
  input  logic [gbi_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: req_type[0]
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata: interp_value[31:0]
  output logic [gbi_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [gbi_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [gbi_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int X_LIM = (MAX_X_POINTS < 127) ? MAX_X_POINTS : 127;
  localparam int Y_LIM = (MAX_Y_POINTS < 127) ? MAX_Y_POINTS : 127;
  localparam int XQB   = $clog2(X_LIM);
  localparam int YQB   = $clog2(Y_LIM);
  localparam int QB    = (XQB > YQB) ? XQB : YQB;  // cell index bits
  localparam int FW    = gbi_pkg::FRAC_W;
  localparam int QW    = QB + FW;                  // quotient bits = divider stages
  localparam int TW    = 32 + QB;
  localparam int CW    = gbi_pkg::CNT_W;
  localparam int AW    = gbi_pkg::STORE_AW;
  localparam int RPW   = QB + CW;
  localparam int SW    = 50;
  localparam int RW    = 37;
  localparam logic signed [SW-1:0] SAT_HI =
    $signed((SW'(1) << (VALUE_WIDTH - 1)) - SW'(1));
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    gbi_pkg::axis_kind_t kind;
    logic [31:0]         span;
    logic [31:0]         rem;
    logic [QW-1:0]       feed;
    logic [QW-1:0]       quo;
  } axis_div_t;

  typedef struct packed {
    logic                v;
    gbi_pkg::item_meta_t meta;
    axis_div_t           ax;
    axis_div_t           ay;
  } div_stage_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic signed [31:0] x_lower_r, x_upper_r, y_lower_r, y_upper_r;
  logic [CW-1:0]      x_cnt_r, y_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_lower_r <= '0;
      x_upper_r <= gbi_pkg::ONE_Q16;
      y_lower_r <= '0;
      y_upper_r <= gbi_pkg::ONE_Q16;
      x_cnt_r   <= CW'(2);
      y_cnt_r   <= CW'(2);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gbi_pkg::CFG_X_LOWER: x_lower_r <= $signed(cfg_wdata);
        gbi_pkg::CFG_X_UPPER: x_upper_r <= $signed(cfg_wdata);
        gbi_pkg::CFG_Y_LOWER: y_lower_r <= $signed(cfg_wdata);
        gbi_pkg::CFG_Y_UPPER: y_upper_r <= $signed(cfg_wdata);
        gbi_pkg::CFG_X_COUNT: x_cnt_r   <= cfg_wdata[CW-1:0];
        gbi_pkg::CFG_Y_COUNT: y_cnt_r   <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Effective point counts: below 2 acts as 2, above the maximum as the maximum
  function automatic logic [CW-1:0] clamp_cnt(logic [CW-1:0] n, int lim);
    logic [CW-1:0] r;
    if (n < CW'(2)) r = CW'(2);
    else if (32'(n) > lim) r = CW'(lim);
    else r = n;
    return r;
  endfunction

  logic [CW-1:0] nx_eff, ny_eff;
  logic [QB-1:0] nx_m1, ny_m1;

  always_comb begin
    nx_eff = clamp_cnt(x_cnt_r, X_LIM);
    ny_eff = clamp_cnt(y_cnt_r, Y_LIM);
    nx_m1  = QB'(nx_eff - CW'(1));
    ny_m1  = QB'(ny_eff - CW'(1));
  end

  // ---------------------------------------------------------------------------
  // Pipeline enable: hold only when the last stage has a result with nowhere to go
  logic s11_qv_r, out_valid_r, out_free, en;
  assign out_free  = !out_valid_r || out_tready;
  assign en        = out_free || !s11_qv_r;
  assign in_tready = en;

  // S1: registered request
  logic                s1_v_r;
  gbi_pkg::item_meta_t s1_meta_r;
  logic signed [31:0]  s1_x_r, s1_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_tvalid;
    if (en) begin
      s1_meta_r.is_query <= (in_tuser[0] == gbi_pkg::REQ_QUERY);
      s1_meta_r.idx      <= in_tdata[gbi_pkg::IDX_LSB +: AW];
      s1_meta_r.value    <= in_tdata[gbi_pkg::VAL_LSB +: 32];
      s1_x_r             <= $signed(in_tdata[gbi_pkg::XC_LSB +: 32]);
      s1_y_r             <= $signed(in_tdata[gbi_pkg::YC_LSB +: 32]);
    end
  end

  // S2: classify each coordinate, offset from the origin, axis span.
  // At or past the upper edge is the high edge: q >= n-1 exactly when c >= upper.
  function automatic gbi_pkg::axis_kind_t axis_locate(logic signed [31:0] c,
      logic signed [31:0] lo, logic signed [31:0] hi);
    logic signed [32:0]  span;
    gbi_pkg::axis_kind_t k;
    span = {hi[31], hi} - {lo[31], lo};
    priority if (c < lo)     k = gbi_pkg::AXIS_LOW;
    else if (span <= 33'sd0) k = gbi_pkg::AXIS_HIGH;
    else if (c >= hi)        k = gbi_pkg::AXIS_HIGH;
    else                     k = gbi_pkg::AXIS_MID;
    return k;
  endfunction

  logic                s2_v_r;
  gbi_pkg::item_meta_t s2_meta_r;
  gbi_pkg::axis_kind_t s2_kx_r, s2_ky_r;
  logic [31:0]         s2_offx_r, s2_offy_r, s2_spanx_r, s2_spany_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (en) s2_v_r <= s1_v_r;
    if (en) begin
      s2_meta_r  <= s1_meta_r;
      s2_kx_r    <= axis_locate(s1_x_r, x_lower_r, x_upper_r);
      s2_ky_r    <= axis_locate(s1_y_r, y_lower_r, y_upper_r);
      s2_offx_r  <= 32'(s1_x_r - x_lower_r);
      s2_offy_r  <= 32'(s1_y_r - y_lower_r);
      s2_spanx_r <= 32'(x_upper_r - x_lower_r);
      s2_spany_r <= 32'(y_upper_r - y_lower_r);
    end
  end

  // S3: t = offset * (n - 1), exact
  logic                s3_v_r;
  gbi_pkg::item_meta_t s3_meta_r;
  gbi_pkg::axis_kind_t s3_kx_r, s3_ky_r;
  logic [31:0]         s3_spanx_r, s3_spany_r;
  logic [TW-1:0]       s3_tx_r, s3_ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= s2_v_r;
    if (en) begin
      s3_meta_r  <= s2_meta_r;
      s3_kx_r    <= s2_kx_r;
      s3_ky_r    <= s2_ky_r;
      s3_spanx_r <= s2_spanx_r;
      s3_spany_r <= s2_spany_r;
      s3_tx_r    <= TW'(s2_offx_r) * TW'(nx_m1);
      s3_ty_r    <= TW'(s2_offy_r) * TW'(ny_m1);
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider: floor(t * 2^16 / span), one quotient bit per stage.
  // The top 32 bits of t are already below span for an interior point, so they
  // seed the remainder; cell = quotient >> 16, fraction = low 16 bits.
  function automatic axis_div_t div_seed(gbi_pkg::axis_kind_t k, logic [31:0] span,
      logic [TW-1:0] t);
    axis_div_t a;
    a.kind = k;
    a.span = span;
    a.rem  = t[TW-1:QB];
    a.feed = {t[QB-1:0], {FW{1'b0}}};
    a.quo  = '0;
    return a;
  endfunction

  function automatic axis_div_t div_step(axis_div_t a);
    axis_div_t  o;
    logic [32:0] trial;
    o       = a;
    trial   = {a.rem, a.feed[QW-1]};
    o.feed  = {a.feed[QW-2:0], 1'b0};
    if (trial >= {1'b0, a.span}) begin
      o.rem = 32'(trial - {1'b0, a.span});
      o.quo = {a.quo[QW-2:0], 1'b1};
    end else begin
      o.rem = trial[31:0];
      o.quo = {a.quo[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  div_stage_t dv_src [QW];
  div_stage_t dv_r   [QW];

  always_comb begin
    dv_src[0].v    = s3_v_r;
    dv_src[0].meta = s3_meta_r;
    dv_src[0].ax   = div_seed(s3_kx_r, s3_spanx_r, s3_tx_r);
    dv_src[0].ay   = div_seed(s3_ky_r, s3_spany_r, s3_ty_r);
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    if (k > 0) begin : g_link
      assign dv_src[k] = dv_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k].v <= 1'b0;
      else if (en) dv_r[k].v <= dv_src[k].v;
      if (en) begin
        dv_r[k].meta <= dv_src[k].meta;
        dv_r[k].ax   <= div_step(dv_src[k].ax);
        dv_r[k].ay   <= div_step(dv_src[k].ay);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // S4: grid indices and row bases. Off-grid axes collapse both neighbors onto
  // the clamped edge with zero fraction, so lerp passes the sample through.
  div_stage_t          dv_last;
  logic [QB-1:0]       xi0_c, xi1_c, yj0_c, yj1_c;
  logic [FW-1:0]       fx_c, fy_c;

  assign dv_last = dv_r[QW-1];

  always_comb begin
    unique case (dv_last.ax.kind)
      gbi_pkg::AXIS_MID: begin
        xi0_c = dv_last.ax.quo[QW-1:FW];
        xi1_c = QB'(dv_last.ax.quo[QW-1:FW] + QB'(1));
        fx_c  = dv_last.ax.quo[FW-1:0];
      end
      gbi_pkg::AXIS_LOW: begin
        xi0_c = '0;
        xi1_c = '0;
        fx_c  = '0;
      end
      default: begin
        xi0_c = nx_m1;
        xi1_c = nx_m1;
        fx_c  = '0;
      end
    endcase
    unique case (dv_last.ay.kind)
      gbi_pkg::AXIS_MID: begin
        yj0_c = dv_last.ay.quo[QW-1:FW];
        yj1_c = QB'(dv_last.ay.quo[QW-1:FW] + QB'(1));
        fy_c  = dv_last.ay.quo[FW-1:0];
      end
      gbi_pkg::AXIS_LOW: begin
        yj0_c = '0;
        yj1_c = '0;
        fy_c  = '0;
      end
      default: begin
        yj0_c = ny_m1;
        yj1_c = ny_m1;
        fy_c  = '0;
      end
    endcase
  end

  logic                s4_v_r;
  gbi_pkg::item_meta_t s4_meta_r;
  logic [AW-1:0]       s4_row0_r, s4_row1_r;
  logic [QB-1:0]       s4_yj0_r, s4_yj1_r;
  logic [FW-1:0]       s4_fx_r, s4_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= dv_last.v;
    if (en) begin
      s4_meta_r <= dv_last.meta;
      s4_row0_r <= AW'(RPW'(xi0_c) * RPW'(ny_eff));
      s4_row1_r <= AW'(RPW'(xi1_c) * RPW'(ny_eff));
      s4_yj0_r  <= yj0_c;
      s4_yj1_r  <= yj1_c;
      s4_fx_r   <= fx_c;
      s4_fy_r   <= fy_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Sample store: four replicas, each written by every load, each read at one
  // corner. Address arithmetic wraps modulo the store depth.
  // Corner order: 0 (i,j), 1 (i+1,j), 2 (i,j+1), 3 (i+1,j+1)
  logic [AW-1:0] ram_raddr [4];
  logic [31:0]   ram_rdata [4];
  logic          ram_we;

  assign ram_we       = en && s4_v_r && !s4_meta_r.is_query;
  assign ram_raddr[0] = s4_row0_r + AW'(s4_yj0_r);
  assign ram_raddr[1] = s4_row1_r + AW'(s4_yj0_r);
  assign ram_raddr[2] = s4_row0_r + AW'(s4_yj1_r);
  assign ram_raddr[3] = s4_row1_r + AW'(s4_yj1_r);

  for (genvar c = 0; c < 4; c++) begin : g_ram
    gbi_ram #(
      .WIDTH (gbi_pkg::SAMPLE_W),
      .DEPTH (gbi_pkg::STORE_DEPTH)
    ) u_ram (
      .clk       (clk),
      .we        (ram_we),
      .waddr     (s4_meta_r.idx),
      .wdata     (s4_meta_r.value),
      .re        (en),
      .raddr     (ram_raddr[c]),
      .rd_data_r (ram_rdata[c])
    );
  end

  // S5: payload alongside the registered RAM data; loads end here
  logic          s5_qv_r;
  logic [FW-1:0] s5_fx_r, s5_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_qv_r <= 1'b0;
    else if (en) s5_qv_r <= s4_v_r && s4_meta_r.is_query;
    if (en) begin
      s5_fx_r <= s4_fx_r;
      s5_fy_r <= s4_fy_r;
    end
  end

  // S6: differences along x
  logic               s6_qv_r;
  logic signed [32:0] s6_d0_r, s6_d1_r;
  logic signed [31:0] s6_s00_r, s6_s01_r;
  logic [FW-1:0]      s6_fx_r, s6_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_qv_r <= 1'b0;
    else if (en) s6_qv_r <= s5_qv_r;
    if (en) begin
      s6_d0_r  <= $signed({ram_rdata[1][31], ram_rdata[1]})
                - $signed({ram_rdata[0][31], ram_rdata[0]});
      s6_d1_r  <= $signed({ram_rdata[3][31], ram_rdata[3]})
                - $signed({ram_rdata[2][31], ram_rdata[2]});
      s6_s00_r <= $signed(ram_rdata[0]);
      s6_s01_r <= $signed(ram_rdata[2]);
      s6_fx_r  <= s5_fx_r;
      s6_fy_r  <= s5_fy_r;
    end
  end

  // S7: difference times x fraction
  logic               s7_qv_r;
  logic signed [49:0] s7_p0_r, s7_p1_r;
  logic signed [31:0] s7_s00_r, s7_s01_r;
  logic [FW-1:0]      s7_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_qv_r <= 1'b0;
    else if (en) s7_qv_r <= s6_qv_r;
    if (en) begin
      s7_p0_r  <= s6_d0_r * $signed({1'b0, s6_fx_r});
      s7_p1_r  <= s6_d1_r * $signed({1'b0, s6_fx_r});
      s7_s00_r <= s6_s00_r;
      s7_s01_r <= s6_s01_r;
      s7_fy_r  <= s6_fy_r;
    end
  end

  // S8: rounded x lerps (arithmetic shift is the floor)
  logic               s8_qv_r;
  logic signed [33:0] s8_lo_r, s8_hi_r;
  logic [FW-1:0]      s8_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s8_qv_r <= 1'b0;
    else if (en) s8_qv_r <= s7_qv_r;
    if (en) begin
      s8_lo_r <= $signed({{2{s7_s00_r[31]}}, s7_s00_r})
               + 34'((s7_p0_r + 50'sd32768) >>> FW);
      s8_hi_r <= $signed({{2{s7_s01_r[31]}}, s7_s01_r})
               + 34'((s7_p1_r + 50'sd32768) >>> FW);
      s8_fy_r <= s7_fy_r;
    end
  end

  // S9: difference along y
  logic               s9_qv_r;
  logic signed [34:0] s9_dy_r;
  logic signed [33:0] s9_lo_r;
  logic [FW-1:0]      s9_fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s9_qv_r <= 1'b0;
    else if (en) s9_qv_r <= s8_qv_r;
    if (en) begin
      s9_dy_r <= $signed({s8_hi_r[33], s8_hi_r}) - $signed({s8_lo_r[33], s8_lo_r});
      s9_lo_r <= s8_lo_r;
      s9_fy_r <= s8_fy_r;
    end
  end

  // S10: difference times y fraction
  logic               s10_qv_r;
  logic signed [51:0] s10_py_r;
  logic signed [33:0] s10_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s10_qv_r <= 1'b0;
    else if (en) s10_qv_r <= s9_qv_r;
    if (en) begin
      s10_py_r <= s9_dy_r * $signed({1'b0, s9_fy_r});
      s10_lo_r <= s9_lo_r;
    end
  end

  // S11: rounded y lerp
  logic signed [RW-1:0] s11_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s11_qv_r <= 1'b0;
    else if (en) s11_qv_r <= s10_qv_r;
    if (en) begin
      s11_r_r <= $signed({{(RW-34){s10_lo_r[33]}}, s10_lo_r})
               + RW'((s10_py_r + 52'sd32768) >>> FW);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: saturate to VALUE_WIDTH, keep the low 32 bits
  logic signed [SW-1:0] r_ext;
  logic signed [SW-1:0] r_sat;
  logic [31:0]          out_data_nxt;
  logic [31:0]          out_data_r;

  always_comb begin
    r_ext = $signed({{(SW-RW){s11_r_r[RW-1]}}, s11_r_r});
    priority if (r_ext > SAT_HI) r_sat = SAT_HI;
    else if (r_ext < SAT_LO)     r_sat = SAT_LO;
    else                         r_sat = r_ext;
    out_data_nxt = r_sat[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (out_free) out_valid_r <= s11_qv_r;
    if (out_free) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/gbi_checker.sv =====
// Port-level checker for the grid bilinear interpolator core, bound to the top.
// Depends on the core's port list only.
`default_nettype none
module gbi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Input side backs up only behind a result that is not being taken
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output backpressure");

endmodule

bind grid_bilinear_interpolator_core gbi_checker u_gbi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for grid_bilinear_interpolator_core: loads sample grids,
// queries points and compares each result against an in-bench fixed point predictor.
// Depends on gbi_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import gbi_pkg::*;

  localparam int STORE_N   = 4096;
  localparam int DRAIN_CYC = 48;    // wait after the last result so loads retire
  localparam int WDOG_MAX  = 5000;  // cycles with no handshake at all
  localparam int N_PHASES  = 8;

  // one stream request, field by field
  typedef struct {
    req_type_t   kind;
    logic [11:0] idx;
    logic [31:0] val;
    logic [31:0] xc;
    logic [31:0] yc;
  } request_t;

  // Grid store and register copy, plus the queue of pending interpolation results
  class interp_scoreboard;
    longint      x_lo, x_hi, y_lo, y_hi;
    int          x_cnt, y_cnt;
    longint      grid[STORE_N];
    logic [31:0] pending_q[$];
    int          errors, n_loads, n_queries, n_results;

    function new();
      x_lo = 0; x_hi = 65536; y_lo = 0; y_hi = 65536;
      x_cnt = 2; y_cnt = 2;
      errors = 0; n_loads = 0; n_queries = 0; n_results = 0;
      foreach (grid[i]) grid[i] = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function void set_register(cfg_reg_t r, logic [31:0] d);
      case (r)
        CFG_X_LOWER: x_lo = longint'($signed(d));
        CFG_X_UPPER: x_hi = longint'($signed(d));
        CFG_Y_LOWER: y_lo = longint'($signed(d));
        CFG_Y_UPPER: y_hi = longint'($signed(d));
        CFG_X_COUNT: x_cnt = int'(d[6:0]);
        CFG_Y_COUNT: y_cnt = int'(d[6:0]);
        default: ;
      endcase
    endfunction

    static function int eff_count(int n, int mx);
      if (n < 2) return 2;
      if (n > mx) return mx;
      return n;
    endfunction

    // place a coordinate on an axis: edge or cell plus Q0.16 fraction
    static function void locate(longint c, longint lo, longint hi, int n,
                                output axis_kind_t k, output int cidx,
                                output longint frac);
      longint span, t, q, r;
      span = hi - lo;
      cidx = 0;
      frac = 0;
      if (c < lo) k = AXIS_LOW;
      else if (span <= 0) k = AXIS_HIGH;
      else begin
        t = (c - lo) * longint'(n - 1);
        q = t / span;
        r = t % span;
        if (q >= n - 1) k = AXIS_HIGH;
        else begin
          k = AXIS_MID;
          cidx = int'(q);
          frac = (r <<< 16) / span;
        end
      end
    endfunction

    // arithmetic shift floors, matching round-half-up on the product
    static function longint blend(longint a, longint b, longint f);
      return a + (((b - a) * f + 32768) >>> 16);
    endfunction

    function longint at(int i, int j, int ny);
      return grid[(i * ny + j) % STORE_N];
    endfunction

    function void note_request(request_t rq);
      int nx, ny, xe, ye, ci, cj;
      axis_kind_t kx, ky;
      longint fx, fy, r, lo_row, hi_row;
      if (rq.kind == REQ_LOAD) begin
        grid[rq.idx] = longint'($signed(rq.val));
        n_loads++;
        return;
      end
      n_queries++;
      nx = eff_count(x_cnt, 64);
      ny = eff_count(y_cnt, 64);
      locate(longint'($signed(rq.xc)), x_lo, x_hi, nx, kx, ci, fx);
      locate(longint'($signed(rq.yc)), y_lo, y_hi, ny, ky, cj, fy);
      xe = (kx == AXIS_LOW) ? 0 : nx - 1;
      ye = (ky == AXIS_LOW) ? 0 : ny - 1;
      if (kx == AXIS_MID && ky == AXIS_MID) begin
        lo_row = blend(at(ci, cj, ny), at(ci + 1, cj, ny), fx);
        hi_row = blend(at(ci, cj + 1, ny), at(ci + 1, cj + 1, ny), fx);
        r = blend(lo_row, hi_row, fy);
      end else if (kx == AXIS_MID) r = blend(at(ci, ye, ny), at(ci + 1, ye, ny), fx);
      else if (ky == AXIS_MID) r = blend(at(xe, cj, ny), at(xe, cj + 1, ny), fy);
      else r = at(xe, ye, ny);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      pending_q.push_back(r[31:0]);
    endfunction

    task check_result(logic [31:0] got);
      logic [31:0] want;
      n_results++;
      if (pending_q.size() == 0) begin
        report("unexpected result", got, 'x);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) report("interp_value", got, want);
    endtask
  endclass

  logic                   clk, rst_n;
  logic                   in_tvalid, in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid, out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  interp_scoreboard sb;
  bit  quiet;      // phase runs with no idling on either side
  int  idle_cyc;   // cycles without any handshake, for the watchdog

  grid_bilinear_interpolator_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 8);
  endfunction

  // push one request; inputs move on the falling edge, the handshake is seen at the rise
  task automatic send(request_t rq);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
    @(negedge clk);
    in_tuser  = rq.kind;
    in_tdata  = '0;
    in_tdata[IDX_LSB +: 12] = rq.idx;
    in_tdata[VAL_LSB +: 32] = rq.val;
    in_tdata[XC_LSB  +: 32] = rq.xc;
    in_tdata[YC_LSB  +: 32] = rq.yc;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(rq);
  endtask

  task automatic load(int idx, logic [31:0] v);
    request_t rq;
    rq.kind = REQ_LOAD; rq.idx = idx[11:0]; rq.val = v;
    rq.xc = $urandom(); rq.yc = $urandom();  // don't-care fields still toggle
    send(rq);
  endtask

  task automatic query(logic [31:0] x, logic [31:0] y);
    request_t rq;
    rq.kind = REQ_QUERY; rq.idx = 12'($urandom()); rq.val = $urandom();
    rq.xc = x; rq.yc = y;
    send(rq);
  endtask

  // drop valid, let every pending result come out, then let loads retire
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t r, logic [31:0] d);
    @(negedge clk);
    cfg_we = 1'b1; cfg_addr = r; cfg_wdata = d;
    sb.set_register(r, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // coordinate near one axis: mostly inside, sometimes past an edge or raw noise
  function automatic logic [31:0] rand_coord(longint lo, longint hi, int n);
    longint span, c;
    span = (hi > lo) ? hi - lo : 64'd65536;
    case ($urandom_range(0, 7))
      0: c = longint'($signed($urandom()));
      1: c = lo + span * $urandom_range(0, n - 1) / (n - 1);  // on a grid line
      2: c = lo - longint'($urandom_range(1, 1 << 20));
      3: c = hi + longint'($urandom_range(0, 1 << 20));
      default: c = lo + (span * longint'($urandom_range(0, 65535))) / 65536;
    endcase
    if (c > 64'sd2147483647) c = 64'sd2147483647;
    if (c < -64'sd2147483648) c = -64'sd2147483648;
    return c[31:0];
  endfunction

  // receiver: random stalls per result, stretches of none when quiet
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap();
      repeat (gap) begin
        @(negedge clk);
        out_tready = 1'b0;
      end
      @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
    end
  end

  // watchdog: a run that stops making progress is a failure
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_MAX) begin
      $display("watchdog: no handshake for %0d cycles", WDOG_MAX);
      $display("grid_bilinear_interpolator_core regression: fail");
      $finish;
    end
  end

  initial begin
    longint xl, xh, yl, yh;
    int nx, ny, xr, yr, nq;
    sb = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = '0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset config is a 2x2 grid over [0,1.0] on both axes.
    load(0, 32'h7FFF_FFFF);
    load(1, 32'h8000_0000);
    load(2, 32'h0000_0000);
    load(3, 32'hFFFF_FFFF);
    query(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // corner below both lowers
    query(32'h7FFF_FFFF, 32'h7FFF_FFFF);  // corner past both uppers
    query(32'h8000_0000, 32'h0000_8000);  // x clamped low, y interior
    query(32'h0000_8000, 32'h0001_0000);  // x interior, y on upper edge
    query(32'h0000_8000, 32'h8000_0000);  // x interior, y clamped low
    query(32'h7FFF_FFFF, 32'h0000_4000);  // x clamped high, y interior
    query(32'h0000_0000, 32'h0000_0000);  // exactly on lower corner
    query(32'h0001_0000, 32'h0001_0000);  // exactly on upper corner
    query(32'h0000_8000, 32'h0000_8000);
    query(32'h0000_4000, 32'h0000_C000);
    query(32'h0000_FFFF, 32'h0000_0001);  // last fraction step before edge
    load(4095, 32'h1234_5678);            // top of the entry range, never read
    load(2, 32'h0000_0001);               // overwrite then read back through a query
    query(32'h0000_8000, 32'h0000_0000);

    for (int ph = 1; ph < N_PHASES; ph++) begin
      drain();  // sender holds off until everything is out
      quiet = ($urandom_range(0, 3) == 0);
      case (ph)
        1: begin  // full extent of both axes, 64 points along x
          xl = -64'sd2147483648; xh = 64'sd2147483647;
          yl = -64'sd2147483648; yh = 64'sd2147483647;
          xr = 127; yr = 2;  // 127 acts as the maximum
        end
        2: begin  // counts below the minimum act as two
          xl = -65536; xh = 65536; yl = 0; yh = 3 * 65536;
          xr = 0; yr = 1;
        end
        3: begin  // empty axes: equal bounds on x, reversed bounds on y
          xl = 65536; xh = 65536; yl = 5 * 65536; yh = -65536;
          xr = $urandom_range(2, 6); yr = $urandom_range(2, 6);
        end
        4: begin  // tiny spans, fraction steps are coarse
          xl = longint'($signed($urandom())); xh = xl + $urandom_range(1, 4);
          yl = -100; yh = yl + $urandom_range(1, 4);
          xr = $urandom_range(2, 5); yr = $urandom_range(2, 5);
          if (xh > 64'sd2147483647) begin xl = 0; xh = 3; end
        end
        default: begin
          xl = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
          xh = xl + $urandom_range(1, 1 << 22);
          yl = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
          yh = yl + $urandom_range(1, 1 << 22);
          xr = $urandom_range(2, 8); yr = $urandom_range(2, 8);
        end
      endcase
      cfg_write(CFG_X_LOWER, xl[31:0]);
      cfg_write(CFG_X_UPPER, xh[31:0]);
      cfg_write(CFG_Y_LOWER, yl[31:0]);
      cfg_write(CFG_Y_UPPER, yh[31:0]);
      cfg_write(CFG_X_COUNT, {25'($urandom_range(0, (1 << 25) - 1)), xr[6:0]});
      cfg_write(CFG_Y_COUNT, {25'($urandom_range(0, (1 << 25) - 1)), yr[6:0]});
      nx = interp_scoreboard::eff_count(xr, 64);
      ny = interp_scoreboard::eff_count(yr, 64);

      // every entry a query can touch is written before any query
      for (int i = 0; i < nx * ny; i++) load(i, rand_sample());

      nq = 0;
      while (nq < 25) begin
        if ($urandom_range(0, 4) == 0) begin
          // reload inside the grid, or write anywhere in the store
          if ($urandom_range(0, 1)) load($urandom_range(0, nx * ny - 1), rand_sample());
          else load($urandom_range(0, STORE_N - 1), rand_sample());
          if ($urandom_range(0, 7) == 0) begin
            // now and then rewrite a small grid in one burst
            for (int i = 0; i < nx * ny && nx * ny <= 64; i++) load(i, rand_sample());
          end
        end else begin
          query(rand_coord(xl, xh, nx), rand_coord(yl, yh, ny));
          nq++;
        end
      end
    end

    drain();
    $display("covered %0d loads and %0d queries over %0d grid setups, %0d results checked",
             sb.n_loads, sb.n_queries, N_PHASES, sb.n_results);
    $display("setups include full-range bounds, a 64-point axis, clamped counts and empty axes");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("grid_bilinear_interpolator_core regression: pass");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.errors, sb.pending_q.size());
      $display("grid_bilinear_interpolator_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
